/* hdl/arp_pkg.sv */
// Shared constants, codes and control types of the atlas rectangle packer.
`default_nettype none
package arp_pkg;
	localparam int FIELD_W       = 13;
	localparam int COORD_MAX     = 4096;
	localparam int MAX_RECTS_DEF = 16;
	localparam int SLOT_W        = 4;
	localparam int EDGE_W        = FIELD_W + 1;
	localparam int SPAN_W        = FIELD_W + 2;
	localparam int AREA_W        = 2 * SPAN_W;
	localparam int IN_DATA_W     = 32;
	localparam int OUT_DATA_W    = 32;
	localparam int STATUS_W      = 2;

	localparam logic [FIELD_W-1:0] COORD_LIM = FIELD_W'(COORD_MAX);

	localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd3;

	localparam logic ACT_PLACE   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic REG_ATLAS_W = 1'b0;
	localparam logic REG_ATLAS_H = 1'b1;

	localparam logic [1:0] FIN_PLACE = 2'd0;
	localparam logic [1:0] FIN_FULL  = 2'd1;
	localparam logic [1:0] FIN_REL   = 2'd2;

	typedef struct packed {
		logic       latch;
		logic       scan_acc;
		logic       origin;
		logic       cand_load;
		logic       corner;
		logic       area;
		logic       take;
		logic       fin;
		logic [1:0] kind;
	} arp_cmd_t;

	typedef struct packed {
		logic free_found;
		logic any;
		logic rd_live;
		logic cand_ok;
		logic hit;
		logic out_free;
	} arp_stat_t;
endpackage
`default_nettype wire

/* hdl/arp_ctrl.sv */
// Sequencer of the packer: slot scan, corner walk and overlap sweep.
`default_nettype none
module arp_ctrl
	import arp_pkg::*;
#(
	parameter int MAX_RECTS = MAX_RECTS_DEF,
	parameter int IDX_W     = $clog2(MAX_RECTS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic             s_action,
	output logic                  s_tready,
	input  wire arp_stat_t        st,
	output arp_cmd_t              cmd,
	output logic [IDX_W-1:0]      rd_idx
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_CAND = 3'd3;
	localparam logic [2:0] S_AREA = 3'd4;
	localparam logic [2:0] S_TEST = 3'd5;
	localparam logic [2:0] S_HIT  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_RECTS - 1);

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
	logic             c_q, c_d;
	logic [1:0]       kind_q, kind_d;
	logic             adv, skip;

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		c_d      = c_q;
		kind_d   = kind_q;
		cmd      = '0;
		cmd.kind = kind_q;
		cmd.corner = c_q;
		rd_idx   = i_q;
		s_tready = 1'b0;
		adv      = 1'b0;
		skip     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					i_d = '0;
					if (s_action == ACT_RELEASE) begin
						kind_d  = FIN_REL;
						state_d = S_DONE;
					end else begin
						kind_d  = FIN_PLACE;
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_acc = 1'b1;
				if (i_q == LAST) begin
					state_d = S_EVAL;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			S_EVAL: begin
				i_d = '0;
				c_d = 1'b0;
				if (!st.free_found) begin
					kind_d  = FIN_FULL;
					state_d = S_DONE;
				end else if (!st.any) begin
					cmd.origin = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_CAND;
				end
			end
			S_CAND: begin
				if (st.rd_live) begin
					cmd.cand_load = 1'b1;
					state_d = S_AREA;
				end else begin
					adv  = 1'b1;
					skip = 1'b1;
				end
			end
			S_AREA: begin
				cmd.area = 1'b1;
				state_d = S_TEST;
			end
			S_TEST: begin
				if (st.cand_ok) begin
					j_d = '0;
					state_d = S_HIT;
				end else begin
					adv = 1'b1;
				end
			end
			S_HIT: begin
				rd_idx = j_q;
				if (st.hit) begin
					adv = 1'b1;
				end else if (j_q == LAST) begin
					cmd.take = 1'b1;
					adv = 1'b1;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (adv) begin
			if (!c_q && !skip) begin
				c_d = 1'b1;
				state_d = S_CAND;
			end else if (i_q == LAST) begin
				state_d = S_DONE;
			end else begin
				i_d = i_q + 1'b1;
				c_d = 1'b0;
				state_d = S_CAND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			c_q     <= 1'b0;
			kind_q  <= FIN_PLACE;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			c_q     <= c_d;
			kind_q  <= kind_d;
		end
	end
endmodule
`default_nettype wire

/* hdl/arp_dp.sv */
// Datapath of the packer: slot table, extents, corner test, area and result register.
`default_nettype none
module arp_dp
	import arp_pkg::*;
#(
	parameter int MAX_RECTS = MAX_RECTS_DEF,
	parameter int IDX_W     = $clog2(MAX_RECTS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire arp_cmd_t              cmd,
	input  wire logic [IDX_W-1:0]      rd_idx,
	output arp_stat_t                  st,
	input  wire logic [FIELD_W-1:0]    req_w,
	input  wire logic [FIELD_W-1:0]    req_h,
	input  wire logic [SLOT_W-1:0]     req_slot,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_index,
	input  wire logic [FIELD_W-1:0]    cfg_data,
	input  wire logic                  m_tready,
	output logic                       m_tvalid,
	output logic [STATUS_W-1:0]        m_status,
	output logic [SLOT_W-1:0]          m_slot,
	output logic [FIELD_W-1:0]         m_pos_x,
	output logic [FIELD_W-1:0]         m_pos_y
);
	logic                 live_q [MAX_RECTS];
	logic [FIELD_W-1:0]   left_q [MAX_RECTS];
	logic [FIELD_W-1:0]   top_q  [MAX_RECTS];
	logic [FIELD_W-1:0]   bw_q   [MAX_RECTS];
	logic [FIELD_W-1:0]   bh_q   [MAX_RECTS];

	logic [FIELD_W-1:0]   aw_q, ah_q, w_q, h_q;
	logic [SLOT_W-1:0]    rs_q;
	logic [EDGE_W-1:0]    maxw_q, maxh_q, x_q, y_q, bx_q, by_q;
	logic                 any_q, free_found_q, found_q, inb_q;
	logic [IDX_W-1:0]     free_q;
	logic [SPAN_W-1:0]    extw_q, exth_q;
	logic [AREA_W-1:0]    area_q, best_q;

	logic                 rd_live;
	logic [EDGE_W-1:0]    rd_l, rd_t, rd_r, rd_b, cx, cy;
	logic [SPAN_W-1:0]    cr, cb;
	logic                 overlap, rel_ok;

	assign rd_live = live_q[rd_idx];
	assign rd_l    = EDGE_W'(left_q[rd_idx]);
	assign rd_t    = EDGE_W'(top_q[rd_idx]);
	assign rd_r    = rd_l + EDGE_W'(bw_q[rd_idx]);
	assign rd_b    = rd_t + EDGE_W'(bh_q[rd_idx]);
	assign cx      = cmd.corner ? rd_l : rd_r;
	assign cy      = cmd.corner ? rd_b : rd_t;
	assign cr      = SPAN_W'(cx) + SPAN_W'(w_q);
	assign cb      = SPAN_W'(cy) + SPAN_W'(h_q);
	assign overlap = (x_q < rd_r) && ((SPAN_W'(x_q) + SPAN_W'(w_q)) > SPAN_W'(rd_l)) &&
	                 (y_q < rd_b) && ((SPAN_W'(y_q) + SPAN_W'(h_q)) > SPAN_W'(rd_t));
	assign rel_ok  = 32'(rs_q) < MAX_RECTS;

	assign st.free_found = free_found_q;
	assign st.any        = any_q;
	assign st.rd_live    = rd_live;
	assign st.cand_ok    = inb_q && (!found_q || (area_q < best_q));
	assign st.hit        = rd_live && overlap;
	assign st.out_free   = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q     <= COORD_LIM;
			ah_q     <= COORD_LIM;
			m_tvalid <= 1'b0;
			for (int k = 0; k < MAX_RECTS; k++) begin
				live_q[k] <= 1'b0;
			end
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_ATLAS_W) begin
					aw_q <= (cfg_data > COORD_LIM) ? COORD_LIM : cfg_data;
				end else begin
					ah_q <= (cfg_data > COORD_LIM) ? COORD_LIM : cfg_data;
				end
			end
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cmd.fin) begin
				m_tvalid <= 1'b1;
				if (cmd.kind == FIN_REL) begin
					if (rel_ok) begin
						live_q[IDX_W'(rs_q)] <= 1'b0;
					end
				end else if (cmd.kind == FIN_PLACE && found_q) begin
					live_q[free_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			w_q          <= req_w;
			h_q          <= req_h;
			rs_q         <= req_slot;
			maxw_q       <= '0;
			maxh_q       <= '0;
			any_q        <= 1'b0;
			free_found_q <= 1'b0;
			found_q      <= 1'b0;
			free_q       <= '0;
		end
		if (cmd.scan_acc) begin
			if (rd_live) begin
				any_q <= 1'b1;
				if (rd_r > maxw_q) maxw_q <= rd_r;
				if (rd_b > maxh_q) maxh_q <= rd_b;
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_q       <= rd_idx;
			end
		end
		if (cmd.origin) begin
			found_q <= 1'b1;
			bx_q    <= '0;
			by_q    <= '0;
		end
		if (cmd.cand_load) begin
			x_q    <= cx;
			y_q    <= cy;
			inb_q  <= (cr <= SPAN_W'(aw_q)) && (cb <= SPAN_W'(ah_q));
			extw_q <= (cr > SPAN_W'(maxw_q)) ? cr : SPAN_W'(maxw_q);
			exth_q <= (cb > SPAN_W'(maxh_q)) ? cb : SPAN_W'(maxh_q);
		end
		if (cmd.area) begin
			area_q <= extw_q * exth_q;
		end
		if (cmd.take) begin
			found_q <= 1'b1;
			best_q  <= area_q;
			bx_q    <= x_q;
			by_q    <= y_q;
		end
		if (cmd.fin) begin
			m_slot  <= '0;
			m_pos_x <= '0;
			m_pos_y <= '0;
			unique case (cmd.kind)
				FIN_REL: begin
					m_status <= ST_RELEASED;
					m_slot   <= rs_q;
				end
				FIN_FULL: begin
					m_status <= ST_FULL;
				end
				default: begin
					if (found_q) begin
						m_status       <= ST_PLACED;
						m_slot         <= SLOT_W'(free_q);
						m_pos_x        <= bx_q[FIELD_W-1:0];
						m_pos_y        <= by_q[FIELD_W-1:0];
						left_q[free_q] <= bx_q[FIELD_W-1:0];
						top_q[free_q]  <= by_q[FIELD_W-1:0];
						bw_q[free_q]   <= w_q;
						bh_q[free_q]   <= h_q;
					end else begin
						m_status <= ST_NOFIT;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/atlas_rect_packer.sv */
// Top level of the atlas rectangle packer.
//  channel  dir  handshake                  payload
//  s_*      in   s_tvalid / s_tready        tuser action; tdata rect_width, rect_height, release_slot
//  m_*      out  m_tvalid / m_tready        tuser status; tdata slot, pos_x, pos_y
//  cfg_*    in   cfg_valid / cfg_ready      cfg_index register, cfg_data value
// One item at a time. A release goes straight to the result. A place scans every slot, then
// skips each free slot and, for each live slot and corner, loads the candidate, takes its
// area and, if it fits and beats the best, sweeps for overlap over the single slot-table read port.
// Reset clears all slots and sets the page to 4096 x 4096.
// A stalled result holds in the output register; the next item is taken meanwhile.
`default_nettype none
module atlas_rect_packer
	import arp_pkg::*;
#(
	parameter int MAX_RECTS = MAX_RECTS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_DATA_W-1:0]   s_tdata,  // rect_width, rect_height, release_slot, pad
	input  wire logic                   s_tuser,  // action
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_DATA_W-1:0]       m_tdata,  // slot, pos_x, pos_y, pad
	output logic [STATUS_W-1:0]         m_tuser,  // status
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_index,
	input  wire logic [FIELD_W-1:0]     cfg_data
);
	localparam int IDX_W = $clog2(MAX_RECTS);

	arp_cmd_t          cmd;
	arp_stat_t         st;
	logic [IDX_W-1:0]  rd_idx;
	logic [SLOT_W-1:0] m_slot;
	logic [FIELD_W-1:0] m_pos_x, m_pos_y;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {2'b00, m_pos_y, m_pos_x, m_slot};

	arp_ctrl #(.MAX_RECTS(MAX_RECTS), .IDX_W(IDX_W)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_action (s_tuser),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd),
		.rd_idx   (rd_idx)
	);

	arp_dp #(.MAX_RECTS(MAX_RECTS), .IDX_W(IDX_W)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.st        (st),
		.req_w     (s_tdata[12:0]),
		.req_h     (s_tdata[25:13]),
		.req_slot  (s_tdata[29:26]),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_status  (m_tuser),
		.m_slot    (m_slot),
		.m_pos_x   (m_pos_x),
		.m_pos_y   (m_pos_y)
	);
endmodule
`default_nettype wire

/* hdl/arp_checker.sv */
// Port-level checks of the atlas rectangle packer and their binding.
`default_nettype none
module arp_checker
	import arp_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_DATA_W-1:0]  m_tdata,
	input wire logic [STATUS_W-1:0]    m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while busy");
	a_rel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_RELEASED |-> m_tdata[31:4] == '0)
		else $error("release result carries a position");
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_NOFIT || m_tuser == ST_FULL) |-> m_tdata == '0)
		else $error("failed placement carries data");
endmodule

bind atlas_rect_packer arp_checker u_arp_checker (.*);
`default_nettype wire
